// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int CNT_BITS     = $clog2(PROD_BITS);

    typedef logic [OPERAND_BITS-1:0] t_operand;
    typedef logic [PROD_BITS-1:0]    t_product;
    typedef logic [CNT_BITS-1:0]     t_count;

    localparam t_operand OPERAND_ONE = t_operand'(1);

endpackage

// ===== rtl/core/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_ready    i_base_value, i_exponent, i_modulus
// output   out        o_valid / i_ready    o_power_result
//
// Every modular multiply of an item is done in a single multiplier followed
// by a remainder unit that retires one product bit per cycle. An item needs
// one multiply to reduce the base, one squaring per exponent bit up to the
// highest set bit, and one more multiply per set bit. Reset is synchronous
// and active low.
// The input is not ready until the result has been taken by the output side.

module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_operand i_base_value,
    input  t_operand i_exponent,
    input  t_operand i_modulus,
    output logic     o_valid,
    input  logic     i_ready,
    output t_operand o_power_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    t_state   r_state;
    t_operand r_e;
    t_operand r_m;
    t_operand r_acc;
    t_operand r_sq;
    t_operand r_opx;
    t_operand r_opy;
    logic     r_start;

    logic     w_mm_done;
    t_operand w_mm_result;

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_x      (r_opx),
        .i_y      (r_opy),
        .i_mod    (r_m),
        .o_done   (w_mm_done),
        .o_result (w_mm_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_m     <= i_modulus;
                        r_opx   <= i_base_value;
                        r_opy   <= OPERAND_ONE;
                        r_start <= 1'b1;
                        r_state <= S_BASE;
                        if (i_modulus == '0) begin
                            r_e   <= '0;
                            r_acc <= '0;
                        end else if (i_modulus == OPERAND_ONE) begin
                            r_e   <= i_exponent;
                            r_acc <= '0;
                        end else begin
                            r_e   <= i_exponent;
                            r_acc <= OPERAND_ONE;
                        end
                    end
                end
                S_BASE: begin
                    if (w_mm_done) begin
                        r_sq    <= w_mm_result;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_e == '0) begin
                        r_state <= S_OUT;
                    end else if (r_e[0]) begin
                        r_opx   <= r_acc;
                        r_opy   <= r_sq;
                        r_start <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_opx   <= r_sq;
                        r_opy   <= r_sq;
                        r_start <= 1'b1;
                        r_state <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_mm_done) begin
                        r_acc   <= w_mm_result;
                        r_opx   <= r_sq;
                        r_opy   <= r_sq;
                        r_start <= 1'b1;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (w_mm_done) begin
                        r_sq    <= w_mm_result;
                        r_e     <= r_e >> 1;
                        r_state <= S_STEP;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_power_result = r_acc;

    a_result_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_m != '0)) |-> (o_power_result < r_m))
        else $error("Result is not reduced below the modulus.");

    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> !r_start)
        else $error("Multiply start lasted more than one cycle.");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_done |-> ((r_state == S_BASE) || (r_state == S_MUL) || (r_state == S_SQR)))
        else $error("Multiply finished while no multiply was pending.");

    a_exponent_spent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_e == '0))
        else $error("Result shown before all exponent bits were used.");

endmodule

// ===== rtl/core/mexp_mulmod.sv =====
`timescale 1ns / 1ps

module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_operand i_x,
    input  t_operand i_y,
    input  t_operand i_mod,
    output logic     o_done,
    output t_operand o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_RED
    } t_state;

    localparam t_count LAST_CNT = t_count'(PROD_BITS - 1);

    t_state   r_state;
    t_operand r_x;
    t_operand r_y;
    t_operand r_m;
    t_product r_prod;
    t_operand r_rem;
    t_count   r_cnt;
    logic     r_done;

    logic [OPERAND_BITS:0] w_shifted;
    logic [OPERAND_BITS:0] w_diff;
    t_operand              n_rem;
    t_product              w_prod;

    assign w_prod    = t_product'(r_x) * t_product'(r_y);
    assign w_shifted = {r_rem, r_prod[PROD_BITS-1]};
    assign w_diff    = w_shifted - {1'b0, r_m};

    always_comb begin
        if (w_shifted >= {1'b0, r_m}) begin
            n_rem = w_diff[OPERAND_BITS-1:0];
        end else begin
            n_rem = w_shifted[OPERAND_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_y     <= i_y;
                        r_m     <= i_mod;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_rem  <= n_rem;
                    r_prod <= {r_prod[PROD_BITS-2:0], 1'b0};
                    r_cnt  <= r_cnt + t_count'(1);
                    if (r_cnt == LAST_CNT) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_rem;

endmodule
